FILE: rtl/core/loc_pkg.sv
// ============================================================================
// loc_pkg
// Shared types and constants for the lock order checker: word layouts,
// opcodes, controller states and the controller/datapath bundles.
// ============================================================================
package loc_pkg;

    // Fixed field widths
    localparam int LEVEL_W = 5;
    localparam int ID_W    = 8;
    localparam int CNT_W   = 32;
    localparam int HCNT_W  = 4;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_TRY     = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_UPDATE,
        ST_CAPTURE,
        ST_RESULT
    } state_t;

    // Input word
    typedef struct packed {
        logic [1:0]         opcode;
        logic [LEVEL_W-1:0] lock_level;
        logic [ID_W-1:0]    lock_id;
    } loc_in_t;

    // Result word
    typedef struct packed {
        logic               violation;
        logic [LEVEL_W-1:0] conflicting_level;
        logic               stored;
        logic               release_found;
        logic [HCNT_W-1:0]  held_count;
        logic               highest_valid;
        logic [LEVEL_W-1:0] highest_level;
        logic [CNT_W-1:0]   acquisitions_total;
        logic [CNT_W-1:0]   releases_total;
        logic [CNT_W-1:0]   violations_total;
        logic [HCNT_W-1:0]  max_held_seen;
    } loc_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic shift;
        logic update;
        logic capture;
    } loc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       scan_done;
        logic       found;
        logic       shift_done;
    } loc_sts_t;

endpackage

FILE: rtl/core/loc_ctrl.sv
// ============================================================================
// loc_ctrl
// Sequencer for the lock order checker: accepts a word, steps the datapath
// through scan, compaction and update, then holds the result word.
// ============================================================================
module loc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  loc_pkg::loc_sts_t sts,
    output loc_pkg::loc_cmd_t cmd
);
    import loc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   scan_needed;
    logic   scan_busy;

    // Only acquire and release walk the table
    assign scan_needed = (sts.opcode == OP_ACQUIRE) || (sts.opcode == OP_RELEASE);
    assign scan_busy   = scan_needed && !sts.scan_done;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!scan_busy) begin
                    if (sts.opcode == OP_RELEASE && sts.found && !sts.shift_done)
                        state_next = ST_SHIFT;
                    else
                        state_next = ST_UPDATE;
                end
            end
            ST_SHIFT: begin
                if (sts.shift_done) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_CAPTURE;
            end
            ST_CAPTURE: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SCAN: begin
                cmd.scan = scan_busy;
            end
            ST_SHIFT: begin
                cmd.shift = !sts.shift_done;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            ST_CAPTURE: begin
                cmd.capture = 1'b1;
            end
            ST_RESULT: begin
                m_valid = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/loc_datapath.sv
// ============================================================================
// loc_datapath
// Held-lock table, scan pointer, compaction pointer, highest-level tracking,
// wrapping counters and the result word register.
// ============================================================================
module loc_datapath #(
    parameter int HELD_DEPTH = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  loc_pkg::loc_cmd_t cmd,
    output loc_pkg::loc_sts_t sts,
    input  loc_pkg::loc_in_t  in_word,
    input  logic              cfg_we,
    input  logic              cfg_bit,
    output loc_pkg::loc_out_t out_word
);
    import loc_pkg::*;

    localparam int CW = $clog2(HELD_DEPTH + 1);
    localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(HELD_DEPTH);

    // Table storage
    logic [LEVEL_W-1:0] held_levels_reg [HELD_DEPTH];
    logic [ID_W-1:0]    held_ids_reg    [HELD_DEPTH];

    // Per-word working registers
    logic [1:0]         op_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    logic [ID_W-1:0]    id_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      pos_reg;
    logic               hit_reg;
    logic [LEVEL_W-1:0] conf_reg;
    logic               found_reg;
    logic               stored_reg;
    logic               max_valid_reg;
    logic [LEVEL_W-1:0] max_level_reg;
    loc_out_t           out_reg;

    // Persistent state
    logic               check_en_reg;
    logic [CW-1:0]      count_reg;
    logic               top_valid_reg;
    logic [LEVEL_W-1:0] top_level_reg;
    logic [CNT_W-1:0]   acq_cnt_reg;
    logic [CNT_W-1:0]   rel_cnt_reg;
    logic [CNT_W-1:0]   viol_cnt_reg;
    logic [CW-1:0]      peak_reg;
    logic [CW-1:0]      peak_next;

    logic [LEVEL_W-1:0] rd_lvl;
    logic [ID_W-1:0]    rd_id;
    logic [CW:0]        pos_inc;
    logic [CW-1:0]      cnt_inc;
    logic               hit_now;
    logic               match_now;
    logic               take_max;
    logic               is_acq;
    logic               append;

    // Table reads: scan pointer and the entry after the compaction pointer
    assign rd_lvl  = held_levels_reg[idx_reg[AW-1:0]];
    assign rd_id   = held_ids_reg[idx_reg[AW-1:0]];
    assign pos_inc = {1'b0, pos_reg} + 1'b1;
    assign cnt_inc = count_reg + 1'b1;

    // Scan step decisions
    assign hit_now   = (op_reg == OP_ACQUIRE) && check_en_reg && !hit_reg
                       && (rd_lvl >= lvl_reg);
    assign match_now = (op_reg == OP_RELEASE) && !found_reg
                       && (rd_lvl == lvl_reg) && (rd_id == id_reg);
    assign take_max  = (op_reg == OP_RELEASE) && !match_now
                       && (!max_valid_reg || rd_lvl > max_level_reg);

    // Append on either acquire form when there is room
    assign is_acq    = (op_reg == OP_ACQUIRE) || (op_reg == OP_TRY);
    assign append    = is_acq && (count_reg != DEPTH_C);
    assign peak_next = (cnt_inc > peak_reg) ? cnt_inc : peak_reg;

    // Status
    assign sts.opcode     = op_reg;
    assign sts.scan_done  = (idx_reg == count_reg);
    assign sts.found      = found_reg;
    assign sts.shift_done = (pos_inc >= {1'b0, count_reg});

    assign out_word = out_reg;

    // Table writes: compaction moves one entry down, append writes the tail
    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            held_levels_reg[pos_reg[AW-1:0]] <= held_levels_reg[pos_inc[AW-1:0]];
            held_ids_reg[pos_reg[AW-1:0]]    <= held_ids_reg[pos_inc[AW-1:0]];
        end else if (cmd.update && append) begin
            held_levels_reg[count_reg[AW-1:0]] <= lvl_reg;
            held_ids_reg[count_reg[AW-1:0]]    <= id_reg;
        end
    end

    // Working registers for the current word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg        <= in_word.opcode;
            lvl_reg       <= in_word.lock_level;
            id_reg        <= in_word.lock_id;
            idx_reg       <= '0;
            pos_reg       <= '0;
            hit_reg       <= 1'b0;
            conf_reg      <= '0;
            found_reg     <= 1'b0;
            stored_reg    <= 1'b0;
            max_valid_reg <= 1'b0;
            max_level_reg <= '0;
        end
        if (cmd.scan) begin
            idx_reg <= idx_reg + 1'b1;
            if (hit_now) begin
                hit_reg  <= 1'b1;
                conf_reg <= rd_lvl;
            end
            if (match_now) begin
                found_reg <= 1'b1;
                pos_reg   <= idx_reg;
            end
            if (take_max) begin
                max_valid_reg <= 1'b1;
                max_level_reg <= rd_lvl;
            end
        end
        if (cmd.shift) begin
            pos_reg <= pos_inc[CW-1:0];
        end
        if (cmd.update && append) begin
            stored_reg <= 1'b1;
        end
    end

    // Persistent state: config, fill count, highest level, counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_en_reg  <= 1'b1;
            count_reg     <= '0;
            top_valid_reg <= 1'b0;
            top_level_reg <= '0;
            acq_cnt_reg   <= '0;
            rel_cnt_reg   <= '0;
            viol_cnt_reg  <= '0;
            peak_reg      <= '0;
        end else begin
            if (cfg_we) check_en_reg <= cfg_bit;
            if (cmd.update) begin
                if (append) begin
                    count_reg <= cnt_inc;
                    peak_reg  <= peak_next;
                    if (!top_valid_reg || lvl_reg > top_level_reg) begin
                        top_valid_reg <= 1'b1;
                        top_level_reg <= lvl_reg;
                    end
                end
                if (op_reg == OP_ACQUIRE) begin
                    acq_cnt_reg <= acq_cnt_reg + 1'b1;
                    if (hit_reg) viol_cnt_reg <= viol_cnt_reg + 1'b1;
                end
                if (op_reg == OP_RELEASE) begin
                    rel_cnt_reg   <= rel_cnt_reg + 1'b1;
                    top_valid_reg <= max_valid_reg;
                    top_level_reg <= max_level_reg;
                    if (found_reg) count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    // Result word
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            out_reg.violation          <= hit_reg;
            out_reg.conflicting_level  <= conf_reg;
            out_reg.stored             <= stored_reg;
            out_reg.release_found      <= found_reg;
            out_reg.held_count         <= HCNT_W'(count_reg);
            out_reg.highest_valid      <= top_valid_reg;
            out_reg.highest_level      <= top_valid_reg ? top_level_reg : '0;
            out_reg.acquisitions_total <= acq_cnt_reg;
            out_reg.releases_total     <= rel_cnt_reg;
            out_reg.violations_total   <= viol_cnt_reg;
            out_reg.max_held_seen      <= HCNT_W'(peak_reg);
        end
    end

    // Fill count never exceeds the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("held count above table depth");

    // Peak always covers the current fill
    a_peak_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg >= count_reg)
        else $error("peak below held count");

    // Highest level is ranked exactly when something is held
    a_top_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        top_valid_reg == (count_reg != '0))
        else $error("highest valid disagrees with held count");

    // Scan pointer stays inside the filled part
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> (idx_reg < count_reg))
        else $error("scan beyond held entries");

endmodule

FILE: rtl/core/lock_order_checker.sv
// ============================================================================
// lock_order_checker
// Lock hierarchy order checker for one thread: held-lock table with
// ordering check on acquire, compaction on release, and usage counters.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one operation word (acquire, try-acquire,
//   release). m_valid/m_ready/m_data return exactly one result word per
//   operation. cfg_valid/cfg_ready/cfg_data write the check enable bit;
//   cfg_ready is always high, and writes belong between operations.
//   One word at a time. An acquire or a release walks the held entries
//   with one comparator, one entry per cycle; a try-acquire or no-op
//   skips the walk. A release that has to close a gap then moves each
//   later entry down one place. Every word then passes the update,
//   capture and result states. s_ready is high only while the block is
//   idle, so the next word is taken the cycle after the result word
//   leaves.
//   A stalled receiver holds the result word in place and the block takes
//   no new word until it is taken.
//   Reset (aresetn low, synchronous) empties the table, clears counters,
//   highest level and peak, and sets check enable to 1.
// ============================================================================
module lock_order_checker #(
    parameter int HELD_DEPTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  loc_pkg::loc_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output loc_pkg::loc_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data
);
    import loc_pkg::*;

    loc_cmd_t cmd;
    loc_sts_t sts;

    // Config register is always writable
    assign cfg_ready = 1'b1;

    // Sequencer
    loc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table, counters and result word
    loc_datapath #(
        .HELD_DEPTH (HELD_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_word  (s_data),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_bit  (cfg_data),
        .out_word (m_data)
    );

endmodule
